// ===== design/ssui_pkg.sv =====
// shared constants and types of the sorted set union / intersection block
package ssui_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned RESULT_CAP = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned RES_W      = $clog2(RESULT_CAP + 1);

  localparam logic MODE_UNION     = 1'b0;
  localparam logic MODE_INTERSECT = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_MERGE = 3'b010,
    ST_FLUSH = 3'b100
  } ssui_state_e;

  typedef logic signed [DATA_W-1:0] ssui_word_t;
  typedef logic [CNT_W-1:0]         ssui_cnt_t;

  // decision of one merge step
  typedef struct packed {
    logic       emit;
    logic       adv_first;
    logic       adv_second;
    logic       done;
    ssui_word_t value;
  } ssui_step_t;

endpackage

// ===== design/sorted_set_union_intersection.sv =====
// top level: load of two sorted lists, merge sequencer and output register
// Loads two ascending lists of signed 32-bit words, one request per cycle while ready; tuser
// picks the list and an element beyond 16 per list is dropped and flagged on every result of
// the run. The request with tlast set starts the merge and the block is not ready until the
// run ends. The merge uses one shared signed comparator, one step per cycle while the output
// side does not stall. Union or intersection is chosen by the mode register, which the user
// must write only while idle; the block does not enforce this.
// An empty result gives one item with none_found set.
module sorted_set_union_intersection (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,     // set_mode
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic signed [31:0]  s_axis_tdata_i,  // item_value
  input  logic                s_axis_tuser_i,  // to_second
  input  logic                s_axis_tlast_i,  // is_final
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic signed [31:0]  m_axis_tdata_o,  // result_value
  output logic [1:0]          m_axis_tuser_o,  // none_found, overflowed
  output logic                m_axis_tlast_o   // result_last
);
  import ssui_pkg::*;

  ssui_state_e state_q, state_d;
  logic        mode_q;
  ssui_cnt_t   first_idx_q, first_idx_d;
  ssui_cnt_t   second_idx_q, second_idx_d;
  logic [RES_W-1:0] res_cnt_q, res_cnt_d;
  logic        pend_valid_q, pend_valid_d;
  ssui_word_t  pend_value_q, pend_value_d;
  logic        out_valid_q, out_valid_d;
  ssui_word_t  out_value_q, out_value_d;
  logic        out_last_q, out_last_d;
  logic        out_none_q, out_none_d;
  logic        out_ovf_q, out_ovf_d;

  logic        in_fire;
  logic        out_free;
  logic        clear;
  ssui_word_t  rd_first, rd_second;
  ssui_cnt_t   first_count, second_count;
  logic        overflow;
  ssui_step_t  step;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign clear           = (state_q == ST_FLUSH) && out_free;

  ssui_store u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (in_fire),
    .wr_second_i     (s_axis_tuser_i),
    .wr_value_i      (s_axis_tdata_i),
    .clear_i         (clear),
    .rd_first_idx_i  (first_idx_q),
    .rd_second_idx_i (second_idx_q),
    .rd_first_o      (rd_first),
    .rd_second_o     (rd_second),
    .first_count_o   (first_count),
    .second_count_o  (second_count),
    .overflow_o      (overflow)
  );

  ssui_cmp u_cmp (
    .first_i     (rd_first),
    .second_i    (rd_second),
    .first_ok_i  (first_idx_q < first_count),
    .second_ok_i (second_idx_q < second_count),
    .cap_ok_i    (res_cnt_q < RES_W'(RESULT_CAP)),
    .mode_i      (mode_q),
    .step_o      (step)
  );

  always_comb begin
    state_d      = state_q;
    first_idx_d  = first_idx_q;
    second_idx_d = second_idx_q;
    res_cnt_d    = res_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_none_d   = out_none_q;
    out_ovf_d    = out_ovf_q;
    case (state_q)
      ST_LOAD: begin
        first_idx_d  = '0;
        second_idx_d = '0;
        res_cnt_d    = '0;
        pend_valid_d = 1'b0;
        if (in_fire && s_axis_tlast_i) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (out_free) begin
          if (step.done) begin
            state_d = ST_FLUSH;
          end else begin
            if (step.adv_first) first_idx_d = first_idx_q + 1'b1;
            if (step.adv_second) second_idx_d = second_idx_q + 1'b1;
            if (step.emit) begin
              res_cnt_d    = res_cnt_q + 1'b1;
              pend_valid_d = 1'b1;
              pend_value_d = step.value;
              // previous pick is known not to be the last one
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_value_d = pend_value_q;
                out_last_d  = 1'b0;
                out_none_d  = 1'b0;
                out_ovf_d   = overflow;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = pend_valid_q ? pend_value_q : '0;
          out_last_d   = 1'b1;
          out_none_d   = !pend_valid_q;
          out_ovf_d    = overflow;
          pend_valid_d = 1'b0;
          state_d      = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      mode_q       <= MODE_UNION;
      first_idx_q  <= '0;
      second_idx_q <= '0;
      res_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_idx_q  <= first_idx_d;
      second_idx_q <= second_idx_d;
      res_cnt_q    <= res_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_value_q <= pend_value_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_none_q   <= out_none_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_none_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== design/ssui_store.sv =====
// two list stores with fill counts and the drop flag
module ssui_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic                wr_second_i,
  input  ssui_pkg::ssui_word_t wr_value_i,
  input  logic                clear_i,
  input  ssui_pkg::ssui_cnt_t  rd_first_idx_i,
  input  ssui_pkg::ssui_cnt_t  rd_second_idx_i,
  output ssui_pkg::ssui_word_t rd_first_o,
  output ssui_pkg::ssui_word_t rd_second_o,
  output ssui_pkg::ssui_cnt_t  first_count_o,
  output ssui_pkg::ssui_cnt_t  second_count_o,
  output logic                overflow_o
);
  import ssui_pkg::*;

  ssui_word_t first_mem [DEPTH];
  ssui_word_t second_mem [DEPTH];
  ssui_cnt_t  first_count_q, first_count_d;
  ssui_cnt_t  second_count_q, second_count_d;
  logic       overflow_q, overflow_d;
  logic       first_full, second_full;

  assign first_full  = (first_count_q == CNT_W'(DEPTH));
  assign second_full = (second_count_q == CNT_W'(DEPTH));

  always_comb begin
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    overflow_d     = overflow_q;
    if (clear_i) begin
      first_count_d  = '0;
      second_count_d = '0;
      overflow_d     = 1'b0;
    end else if (wr_en_i) begin
      if (wr_second_i) begin
        if (second_full) overflow_d = 1'b1;
        else second_count_d = second_count_q + 1'b1;
      end else begin
        if (first_full) overflow_d = 1'b1;
        else first_count_d = first_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= '0;
      second_count_q <= '0;
      overflow_q     <= 1'b0;
    end else begin
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      overflow_q     <= overflow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clear_i) begin
      if (wr_second_i && !second_full) second_mem[second_count_q[IDX_W-1:0]] <= wr_value_i;
      if (!wr_second_i && !first_full) first_mem[first_count_q[IDX_W-1:0]] <= wr_value_i;
    end
  end

  assign rd_first_o     = first_mem[rd_first_idx_i[IDX_W-1:0]];
  assign rd_second_o    = second_mem[rd_second_idx_i[IDX_W-1:0]];
  assign first_count_o  = first_count_q;
  assign second_count_o = second_count_q;
  assign overflow_o     = overflow_q;

endmodule

// ===== design/ssui_cmp.sv =====
// shared signed compare and pick unit for one merge step
module ssui_cmp (
  input  ssui_pkg::ssui_word_t first_i,
  input  ssui_pkg::ssui_word_t second_i,
  input  logic                first_ok_i,
  input  logic                second_ok_i,
  input  logic                cap_ok_i,
  input  logic                mode_i,
  output ssui_pkg::ssui_step_t step_o
);
  import ssui_pkg::*;

  logic is_union;

  assign is_union = (mode_i == MODE_UNION);

  always_comb begin
    step_o = '{emit: 1'b0, adv_first: 1'b0, adv_second: 1'b0, done: 1'b0, value: first_i};
    if (first_ok_i && second_ok_i && cap_ok_i) begin
      if (first_i > second_i) begin
        step_o.emit       = is_union;
        step_o.adv_second = 1'b1;
        step_o.value      = second_i;
      end else if (first_i < second_i) begin
        step_o.emit      = is_union;
        step_o.adv_first = 1'b1;
      end else begin
        step_o.emit       = 1'b1;
        step_o.adv_first  = 1'b1;
        step_o.adv_second = 1'b1;
      end
    end else if (is_union && first_ok_i && cap_ok_i) begin
      step_o.emit      = 1'b1;
      step_o.adv_first = 1'b1;
    end else if (is_union && second_ok_i && cap_ok_i) begin
      step_o.emit       = 1'b1;
      step_o.adv_second = 1'b1;
      step_o.value      = second_i;
    end else begin
      step_o.done = 1'b1;
    end
  end

endmodule

// ===== test/sorted_set_union_intersection_tb.sv =====
// testbench of the sorted set union / intersection block: directed table, random runs, scoreboard
`timescale 1ns / 100ps

module sorted_set_union_intersection_tb;
  import ssui_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 480;

  typedef struct packed {
    ssui_word_t value;
    logic       last;
    logic       none_found;
    logic       overflowed;
  } set_item_t;

  typedef struct packed {
    logic       mode;
    int         rep;
    ssui_word_t value;
    ssui_word_t stride;
    logic       to_second;
    logic       is_final;
    logic       typed;
    set_item_t  want;
  } step_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_wdata = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic signed [31:0] s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic signed [31:0] m_tdata;
  logic [1:0]       m_tuser;
  logic             m_tlast;

  ssui_word_t first_list [DEPTH];
  ssui_word_t second_list[DEPTH];
  int         first_len = 0;
  int         second_len = 0;
  logic       drop_seen = 1'b0;
  logic       model_mode = MODE_UNION;
  set_item_t  run_results[$];
  set_item_t  expected_items[$];

  set_item_t  typed_item;
  logic       typed_armed = 1'b0;
  logic       mode_now = MODE_UNION;
  logic       calm = 1'b0;
  int         errors = 0;
  int         quiet = 0;
  int         requests_seen = 0;
  int         results_seen = 0;
  int         runs_seen = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  step_row_t  plan[$];

  sorted_set_union_intersection dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic absorb_element(input ssui_word_t v, input logic sec, input logic fin);
    ssui_word_t found[$];
    int i;
    int j;
    run_results.delete();
    if (sec) begin
      if (second_len < DEPTH) begin
        second_list[second_len] = v;
        second_len++;
      end else begin
        drop_seen = 1'b1;
      end
    end else begin
      if (first_len < DEPTH) begin
        first_list[first_len] = v;
        first_len++;
      end else begin
        drop_seen = 1'b1;
      end
    end
    if (!fin) return;
    i = 0;
    j = 0;
    while (i < first_len && j < second_len && found.size() < RESULT_CAP) begin
      if (first_list[i] > second_list[j]) begin
        if (model_mode == MODE_UNION) found.push_back(second_list[j]);
        j++;
      end else if (first_list[i] < second_list[j]) begin
        if (model_mode == MODE_UNION) found.push_back(first_list[i]);
        i++;
      end else begin
        found.push_back(first_list[i]);
        i++;
        j++;
      end
    end
    if (model_mode == MODE_UNION) begin
      while (i < first_len && found.size() < RESULT_CAP) begin
        found.push_back(first_list[i]);
        i++;
      end
      while (j < second_len && found.size() < RESULT_CAP) begin
        found.push_back(second_list[j]);
        j++;
      end
    end
    if (found.size() == 0) begin
      run_results.push_back(set_item_t'{value: '0, last: 1'b1, none_found: 1'b1,
                                        overflowed: drop_seen});
    end else begin
      foreach (found[k]) begin
        run_results.push_back(set_item_t'{value: found[k], last: (k == found.size() - 1),
                                          none_found: 1'b0, overflowed: drop_seen});
      end
    end
    first_len = 0;
    second_len = 0;
    drop_seen = 1'b0;
  endtask

  always @(posedge clk_i) begin : scoreboard
    set_item_t want;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we) model_mode = cfg_wdata;
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        results_seen++;
        if (expected_items.size() == 0) begin
          $error("result with nothing expected: value %0d", m_tdata);
          errors++;
        end else begin
          want = expected_items.pop_front();
          if (m_tdata !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("result_last: expected %0b, got %0b", want.last, m_tlast);
            errors++;
          end
          if (m_tuser[0] !== want.none_found) begin
            $error("none_found: expected %0b, got %0b", want.none_found, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed, m_tuser[1]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        requests_seen++;
        absorb_element(s_tdata, s_tuser, s_tlast);
        if (s_tlast) begin
          runs_seen++;
          if (typed_armed) begin
            expected_items.push_back(typed_item);
            typed_armed = 1'b0;
          end else begin
            foreach (run_results[k]) expected_items.push_back(run_results[k]);
          end
        end
      end
      quiet = moved ? 0 : quiet + 1;
    end
  end

  // receiver: random stalls, one long hold-off once 60 results have been seen
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = 299;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    wait (rst_ni);
    while (quiet < QUIET_LIMIT) @(posedge clk_i);
    $display("** sorted_set_union_intersection: FAILED **");
    $finish;
  end

  task automatic send_item(input ssui_word_t v, input logic sec, input logic fin);
    while (!calm && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= sec;
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_items.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    mode_now  = m;
  endtask

  function automatic step_row_t plan_row(logic m, int rep, ssui_word_t v, ssui_word_t stride,
                                         logic sec, logic fin, logic typed,
                                         ssui_word_t wv, logic wnone, logic wovf);
    step_row_t r;
    r.mode      = m;
    r.rep       = rep;
    r.value     = v;
    r.stride    = stride;
    r.to_second = sec;
    r.is_final  = fin;
    r.typed     = typed;
    r.want      = '{value: wv, last: 1'b1, none_found: wnone, overflowed: wovf};
    return r;
  endfunction

  task automatic fill_list(input int len, input logic wide, input logic jumbled,
                           ref ssui_word_t vals[$]);
    longint acc;
    vals.delete();
    acc = wide ? (-longint'($urandom_range(32'h7FFF_FFFF)) - 1)
               : (longint'($urandom_range(20)) - 10);
    for (int k = 0; k < len; k++) begin
      if (jumbled) begin
        vals.push_back(wide ? ssui_word_t'($urandom)
                            : ssui_word_t'(int'($urandom_range(20)) - 10));
      end else begin
        vals.push_back(ssui_word_t'(acc));
        acc += wide ? longint'($urandom_range(32'h03FF_FFFF)) : longint'($urandom_range(3));
      end
    end
  endtask

  task automatic play_run(output int sent);
    ssui_word_t a_vals[$];
    ssui_word_t b_vals[$];
    ssui_word_t last_v;
    int         shape;
    int         len_a;
    int         len_b;
    logic       wide;
    logic       fin_sec;
    logic       pick;
    shape = $urandom_range(99);
    wide  = 1'($urandom_range(1));
    len_a = $urandom_range(6);
    len_b = $urandom_range(6);
    if (shape < 8) len_a = $urandom_range(8, 16);
    if (shape >= 90) begin
      wide = 1'b0;
      if ($urandom_range(1)) len_a = $urandom_range(17, 20);
      else len_b = $urandom_range(17, 20);
    end
    if (len_a + len_b == 0) len_b = 1;
    fill_list(len_a, wide, shape >= 80 && shape < 90, a_vals);
    fill_list(len_b, wide, shape >= 80 && shape < 90, b_vals);
    sent = len_a + len_b;
    fin_sec = (a_vals.size() == 0) ? 1'b1 : (b_vals.size() == 0) ? 1'b0
                                                                  : 1'($urandom_range(1));
    last_v  = fin_sec ? b_vals.pop_back() : a_vals.pop_back();
    while (a_vals.size() + b_vals.size() > 0) begin
      pick = (a_vals.size() == 0) ? 1'b1 : (b_vals.size() == 0) ? 1'b0
                                                                : 1'($urandom_range(1));
      if (pick) send_item(b_vals.pop_front(), 1'b1, 1'b0);
      else send_item(a_vals.pop_front(), 1'b0, 1'b0);
    end
    send_item(last_v, fin_sec, 1'b1);
  endtask

  initial begin
    int total;
    int sent;
    int run_no;
    plan.push_back(plan_row(MODE_UNION, 1, 32'sh7FFF_FFFF, 0, 1'b0, 1'b1, 1'b1,
                            32'sh7FFF_FFFF, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_UNION, 1, 32'sh8000_0000, 0, 1'b1, 1'b1, 1'b1,
                            32'sh8000_0000, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_UNION, 1, 1, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_UNION, 1, 1, 0, 1'b1, 1'b1, 1'b1, 1, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_UNION, 1, -3, 0, 1'b1, 1'b0, 1'b0, 0, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_UNION, 1, 0, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_UNION, 1, 9, 0, 1'b0, 1'b1, 1'b0, 0, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_INTERSECT, 1, -5, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_INTERSECT, 1, 7, 0, 1'b1, 1'b1, 1'b1, 0, 1'b1, 1'b0));
    plan.push_back(plan_row(MODE_INTERSECT, 1, 3, 0, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_INTERSECT, 1, 3, 0, 1'b1, 1'b1, 1'b1, 3, 1'b0, 1'b0));
    // first list over capacity, the extra element is dropped
    plan.push_back(plan_row(MODE_INTERSECT, DEPTH + 1, 0, 1, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
    plan.push_back(plan_row(MODE_INTERSECT, 1, 5, 0, 1'b1, 1'b1, 1'b1, 5, 1'b0, 1'b1));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      if (r == 0 || plan[r].mode != mode_now) write_mode(plan[r].mode);
      for (int k = 0; k < plan[r].rep; k++) begin
        if (k == plan[r].rep - 1 && plan[r].is_final && plan[r].typed) begin
          typed_item  = plan[r].want;
          typed_armed = 1'b1;
        end
        send_item(plan[r].value + k * plan[r].stride, plan[r].to_second,
                  plan[r].is_final && (k == plan[r].rep - 1));
      end
    end

    total  = 0;
    run_no = 0;
    while (total < RANDOM_REQUESTS) begin
      if ($urandom_range(99) < 25) write_mode(~mode_now);
      if (run_no == 40) settle();
      calm = (run_no >= 20 && run_no < 35);
      play_run(sent);
      total += sent;
      run_no++;
    end
    calm = 1'b0;

    settle();
    repeat (16) @(negedge clk_i);
    $display("covered %0d requests in %0d runs with %0d results checked,", requests_seen,
             runs_seen, results_seen);
    $display("both modes, dropped elements, empty results and unordered lists included");
    if (errors == 0) begin
      $display("** sorted_set_union_intersection: PASSED **");
    end else begin
      $display("** sorted_set_union_intersection: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ssui_pkg.sv
design/ssui_store.sv
design/ssui_cmp.sv
design/sorted_set_union_intersection.sv
test/sorted_set_union_intersection_tb.sv
